// File: design/ble_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_pkg
// Command codes, result codes and controller/datapath interface types for
// the bounded list engine.
// ----------------------------------------------------------------------------
package ble_pkg;

    localparam logic [2:0] MODE_INSERT  = 3'd0;
    localparam logic [2:0] MODE_SEARCH  = 3'd1;
    localparam logic [2:0] MODE_DELETE  = 3'd2;
    localparam logic [2:0] MODE_REVERSE = 3'd3;
    localparam logic [2:0] MODE_DUMP    = 3'd4;
    localparam logic [2:0] MODE_CLEAR   = 3'd5;

    localparam logic [2:0] ST_DONE     = 3'd0;
    localparam logic [2:0] ST_FOUND    = 3'd1;
    localparam logic [2:0] ST_NOTFOUND = 3'd2;
    localparam logic [2:0] ST_DELETED  = 3'd3;
    localparam logic [2:0] ST_DELFAIL  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_ELEMENT  = 3'd6;
    localparam logic [2:0] ST_EMPTY    = 3'd7;

    // controller -> datapath
    typedef struct packed {
        logic       load;
        logic       idx_clr;
        logic       idx_inc;
        logic       rd;
        logic       rd_next;
        logic       wr_ins;
        logic       wr_shift;
        logic       cnt_dec;
        logic       cnt_clr;
        logic       rev_flip;
        logic       emit;
        logic       emit_elem;
        logic       emit_last;
        logic [2:0] status;
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [2:0] mode;
        logic       full;
        logic       empty;
        logic       at_end;
        logic       next_end;
        logic       match;
        logic       out_free;
    } t_sts;

endpackage

// File: design/ble_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_dpath
// List storage as a circular buffer with head pointer, element count and a
// direction flag, plus the walk index, compare and the output register.
// ----------------------------------------------------------------------------
module ble_dpath
    import ble_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_sts        o_sts,
    input  logic [2:0]  i_mode,
    input  logic [31:0] i_value,
    output logic        o_tvalid,
    input  logic        i_tready,
    output logic [31:0] o_tdata,
    output logic [2:0]  o_tuser,
    output logic        o_tlast
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);

    logic [31:0]   r_mem [CAPACITY];
    logic [2:0]    r_mode;
    logic [31:0]   r_value;
    logic [AW-1:0] r_head;
    logic [CW-1:0] r_count;
    logic          r_rev;
    logic [AW-1:0] r_idx;
    logic [31:0]   r_rdata;
    logic          r_out_valid;
    logic [31:0]   r_out_data;
    logic [2:0]    r_out_st;
    logic          r_out_last;

    logic [AW-1:0] w_idx_nx;
    logic [AW-1:0] w_rd_idx;
    logic [AW-1:0] w_rd_addr;
    logic [AW-1:0] w_sh_addr;
    logic [AW-1:0] w_head_dec;
    logic [AW-1:0] w_head_inc;
    logic [AW-1:0] w_tail_addr;
    logic [AW:0]   w_tail_sum;
    logic [AW-1:0] w_wr_addr;
    logic [31:0]   w_wr_data;
    logic          w_wr_en;
    logic [CW-1:0] w_cnt_m1;

    // logical position -> physical slot; reversed lists count from the tail
    function automatic logic [AW-1:0] f_phys(input logic [AW-1:0] idx,
                                             input logic [AW-1:0] head,
                                             input logic [CW-1:0] cnt,
                                             input logic          rev);
        logic [AW-1:0] off;
        logic [AW:0]   sum;
        off = rev ? AW'(cnt - CW'(1) - CW'(idx)) : idx;
        sum = {1'b0, off} + {1'b0, head};
        if (sum >= (AW+1)'(CAPACITY)) begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    assign w_idx_nx   = r_idx + AW'(1);
    assign w_rd_idx   = i_cmd.rd_next ? w_idx_nx : r_idx;
    assign w_rd_addr  = f_phys(w_rd_idx, r_head, r_count, r_rev);
    assign w_sh_addr  = f_phys(r_idx, r_head, r_count, r_rev);
    assign w_head_dec = (r_head == '0) ? AW'(CAPACITY - 1) : r_head - AW'(1);
    assign w_head_inc = (r_head == AW'(CAPACITY - 1)) ? '0 : r_head + AW'(1);
    assign w_cnt_m1   = r_count - CW'(1);

    // slot just past the physical tail, new front of a reversed list
    always_comb begin
        w_tail_sum = {1'b0, r_head} + (AW+1)'(r_count);
        if (w_tail_sum >= (AW+1)'(CAPACITY)) begin
            w_tail_sum = w_tail_sum - (AW+1)'(CAPACITY);
        end
        w_tail_addr = w_tail_sum[AW-1:0];
    end

    assign w_wr_en   = i_cmd.wr_ins | i_cmd.wr_shift;
    assign w_wr_addr = i_cmd.wr_ins ? (r_rev ? w_tail_addr : w_head_dec) : w_sh_addr;
    assign w_wr_data = i_cmd.wr_ins ? r_value : r_rdata;

    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            r_mem[w_wr_addr] <= w_wr_data;
        end
        if (i_cmd.rd) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_value <= i_value;
        end
        if (i_cmd.idx_clr) begin
            r_idx <= '0;
        end else if (i_cmd.idx_inc) begin
            r_idx <= w_idx_nx;
        end
        if (i_cmd.emit) begin
            r_out_data <= i_cmd.emit_elem ? r_rdata : 32'd0;
            r_out_st   <= i_cmd.status;
            r_out_last <= i_cmd.emit_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_count     <= '0;
            r_rev       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.wr_ins && !r_rev) begin
                r_head <= w_head_dec;
            end else if (i_cmd.cnt_dec && r_rev) begin
                // reversed list ends at the head slot, so dropping the tail moves it
                r_head <= w_head_inc;
            end
            if (i_cmd.cnt_clr) begin
                r_count <= '0;
            end else if (i_cmd.wr_ins) begin
                r_count <= r_count + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_count <= w_cnt_m1;
            end
            if (i_cmd.rev_flip) begin
                r_rev <= ~r_rev;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.mode     = r_mode;
    assign o_sts.full     = (r_count == CW'(CAPACITY));
    assign o_sts.empty    = (r_count == '0);
    assign o_sts.at_end   = (CW'(r_idx) == w_cnt_m1);
    assign o_sts.next_end = ((CW'(r_idx) + CW'(1)) == w_cnt_m1);
    assign o_sts.match    = (r_rdata == r_value);
    assign o_sts.out_free = ~r_out_valid | i_tready;

    assign o_tvalid = r_out_valid;
    assign o_tdata  = r_out_data;
    assign o_tuser  = r_out_st;
    assign o_tlast  = r_out_last;

endmodule

// File: design/ble_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_ctrl
// Command sequencer: decodes each item, issues insert, reverse and clear directly,
// and steps the datapath through scan, shift-down and dump walks.
// ----------------------------------------------------------------------------
module ble_ctrl
    import ble_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_DECODE = 4'd1;
    localparam logic [3:0] S_EMIT   = 4'd2;
    localparam logic [3:0] S_SRD    = 4'd3;
    localparam logic [3:0] S_SCMP   = 4'd4;
    localparam logic [3:0] S_SHRD   = 4'd5;
    localparam logic [3:0] S_SHWR   = 4'd6;
    localparam logic [3:0] S_DRD    = 4'd7;
    localparam logic [3:0] S_DEMIT  = 4'd8;

    logic [3:0] r_state;
    logic [3:0] n_state;
    logic [2:0] r_st;
    logic [2:0] n_st;

    always_comb begin
        n_state = r_state;
        n_st    = r_st;
        o_cmd   = '0;
        o_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DECODE;
                end
            end
            S_DECODE: begin
                n_state = S_EMIT;
                case (i_sts.mode)
                    MODE_INSERT: begin
                        if (i_sts.full) begin
                            n_st = ST_FULL;
                        end else begin
                            o_cmd.wr_ins = 1'b1;
                            n_st         = ST_DONE;
                        end
                    end
                    MODE_SEARCH, MODE_DELETE: begin
                        if (i_sts.empty) begin
                            n_st = (i_sts.mode == MODE_SEARCH) ? ST_NOTFOUND : ST_DELFAIL;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_SRD;
                        end
                    end
                    MODE_REVERSE: begin
                        o_cmd.rev_flip = 1'b1;
                        n_st           = ST_DONE;
                    end
                    MODE_DUMP: begin
                        if (i_sts.empty) begin
                            n_st = ST_EMPTY;
                        end else begin
                            o_cmd.idx_clr = 1'b1;
                            n_state       = S_DRD;
                        end
                    end
                    MODE_CLEAR: begin
                        o_cmd.cnt_clr = 1'b1;
                        n_st          = ST_DONE;
                    end
                    default: begin
                        n_state = S_IDLE;
                    end
                endcase
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_last = 1'b1;
                    o_cmd.status    = r_st;
                    n_state         = S_IDLE;
                end
            end
            S_SRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_SCMP;
            end
            S_SCMP: begin
                if (i_sts.match) begin
                    if (i_sts.mode == MODE_SEARCH) begin
                        n_st    = ST_FOUND;
                        n_state = S_EMIT;
                    end else if (i_sts.at_end) begin
                        // match is the last element: nothing to shift
                        o_cmd.cnt_dec = 1'b1;
                        n_st          = ST_DELETED;
                        n_state       = S_EMIT;
                    end else begin
                        n_state = S_SHRD;
                    end
                end else if (i_sts.at_end) begin
                    n_st    = (i_sts.mode == MODE_SEARCH) ? ST_NOTFOUND : ST_DELFAIL;
                    n_state = S_EMIT;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                    n_state       = S_SRD;
                end
            end
            S_SHRD: begin
                o_cmd.rd      = 1'b1;
                o_cmd.rd_next = 1'b1;
                n_state       = S_SHWR;
            end
            S_SHWR: begin
                // move element idx+1 down to idx
                o_cmd.wr_shift = 1'b1;
                o_cmd.idx_inc  = 1'b1;
                if (i_sts.next_end) begin
                    o_cmd.cnt_dec = 1'b1;
                    n_st          = ST_DELETED;
                    n_state       = S_EMIT;
                end else begin
                    n_state = S_SHRD;
                end
            end
            S_DRD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_DEMIT;
            end
            S_DEMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.emit      = 1'b1;
                    o_cmd.emit_elem = 1'b1;
                    o_cmd.emit_last = i_sts.at_end;
                    o_cmd.status    = ST_ELEMENT;
                    if (i_sts.at_end) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state       = S_DRD;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_st    <= ST_DONE;
        end else begin
            r_state <= n_state;
            r_st    <= n_st;
        end
    end

endmodule

// File: design/bounded_list_engine_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_engine_top
// Bounded ordered list of signed 32-bit values with insert-at-front, search,
// delete-first-match, reverse, dump and clear commands.
// ----------------------------------------------------------------------------
//  channel  | direction | tdata           | tuser       | tlast
//  s (cmd)  | in        | [31:0] value    | [2:0] mode  | -
//  m (res)  | out       | [31:0] item_val | [2:0] status| last result of item
//
//  one item at a time; insert, reverse and clear go through decode, then emit
//  search and delete read, then compare each element visited (one-port memory
//  with registered read), delete adds a read and a write per element shifted
//  dump reads, then emits each element; a stalled result port holds the walk
//  reset empties the list at once, no clearing pass
// ----------------------------------------------------------------------------
module bounded_list_engine_top
    import ble_pkg::*;
#(
    parameter int CAPACITY = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] value
    input  logic [2:0]  i_s_tuser,   // [2:0] mode
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [31:0] o_m_tdata,   // [31:0] item_value
    output logic [2:0]  o_m_tuser,   // [2:0] status
    output logic        o_m_tlast
);

    t_cmd w_cmd;
    t_sts w_sts;

    ble_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .o_ready (o_s_tready),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    ble_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .o_sts    (w_sts),
        .i_mode   (i_s_tuser),
        .i_value  (i_s_tdata),
        .o_tvalid (o_m_tvalid),
        .i_tready (i_m_tready),
        .o_tdata  (o_m_tdata),
        .o_tuser  (o_m_tuser),
        .o_tlast  (o_m_tlast)
    );

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && o_s_tready |=> !o_s_tready)
        else $error("second item taken while one is in progress");

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.emit |-> w_sts.out_free)
        else $error("result loaded over an undelivered one");

    a_ins_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.wr_ins |-> !w_sts.full)
        else $error("insert into a full list");

    a_only_dump_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !o_m_tlast |-> o_m_tuser == ST_ELEMENT)
        else $error("non-final result that is not a dump element");

endmodule
